// ===== rtl/msp_pkg.sv =====
package msp_pkg;

    // Block configuration.
    localparam int NUM_STACKS = 10;
    localparam int POOL_DEPTH = 64;
    localparam int DATA_WIDTH = 32;

    // Fixed widths of the channel fields.
    localparam int IDX_W    = 6;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    // Derived widths. A node pointer holds every node number plus the null mark.
    localparam int ADDR_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PTR_W     = $clog2(POOL_DEPTH + 1);
    localparam int STK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // The null mark ends every stack and the free list.
    localparam ptr_t NIL_PTR = PTR_W'(POOL_DEPTH);

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // Operation codes.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // One entry of the node pool: the node below it and its stored value.
    typedef struct packed {
        ptr_t  link;
        data_t value;
    } node_t;

    // Fits a channel value to the stored width, keeping the low bits.
    function automatic data_t to_data(input logic [FIELD_W-1:0] v);
        logic [DATA_WIDTH+FIELD_W-1:0] ext;
        ext = {{DATA_WIDTH{1'b0}}, v};
        return ext[DATA_WIDTH-1:0];
    endfunction

    // Fits a stored value back to the channel width, zero extended.
    function automatic logic [FIELD_W-1:0] from_data(input data_t d);
        logic [DATA_WIDTH+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, d};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/msp_node_ram.sv =====
module msp_node_ram
    import msp_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output node_t             rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  node_t             wr_data
);

    // Node pool storage; contents are undefined until written.
    node_t mem [POOL_DEPTH];
    node_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/msp_top_table.sv =====
module msp_top_table
    import msp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [STK_IDX_W-1:0] rd_idx,
    output ptr_t                 rd_top,
    input  logic                 wr_en,
    input  logic [STK_IDX_W-1:0] wr_idx,
    input  ptr_t                 wr_top
);

    // Top pointer of each stack; reset leaves every stack empty.
    ptr_t top_reg [NUM_STACKS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                top_reg[i] <= NIL_PTR;
            end
        end else if (wr_en) begin
            top_reg[wr_idx] <= wr_top;
        end
    end

    assign rd_top = top_reg[rd_idx];

endmodule

// ===== rtl/multi_stack_shared_pool.sv =====
// A new input is taken only after the write-back of the previous one, since the node RAM
// read is registered and must return a node's link before the write-back can take place.
// The result is loaded into the output register when the write-back completes, which is
// held off while the output register still holds an earlier result that waits.
// A new input is taken while an earlier result still waits for its transfer.
// Reset (aresetn, synchronous, active low) empties every stack and the free list at once;
// the node RAM is not cleared and no clearing pass is needed.
module multi_stack_shared_pool
    import msp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [IDX_W-1:0]           s_stack_index,
    input  logic signed [FIELD_W-1:0]  s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [FIELD_W-1:0]  m_popped_value
);

    // The controller either waits for an input transfer or completes the write-back.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    // Free list head and the count of nodes ever handed out.
    ptr_t free_head_reg, free_head_next;
    ptr_t fresh_reg, fresh_next;

    // Operation held between the input transfer and its write-back.
    logic                  act_reg;
    logic [STK_IDX_W-1:0]  idx_reg;
    logic [STATUS_W-1:0]   status_reg;
    ptr_t                  node_reg;
    logic                  use_free_reg;
    ptr_t                  old_top_reg;
    data_t                 val_reg;

    // Output register, so that a waiting result does not hold up the input side.
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [FIELD_W-1:0]    m_popped_reg;

    logic                  in_xfer;
    logic                  bad_index;
    logic [STK_IDX_W-1:0]  tbl_rd_idx;
    ptr_t                  tbl_rd_top;
    logic [STATUS_W-1:0]   acc_status;
    ptr_t                  acc_node;
    logic                  acc_use_free;
    logic                  acc_read;

    logic                  done;
    logic                  ok;
    node_t                 rd_data;
    node_t                 wr_data;
    ptr_t                  tbl_wr_top;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // An index at or above the stack count is refused before anything else is checked.
    assign bad_index  = {1'b0, s_stack_index} >= (IDX_W + 1)'(NUM_STACKS);
    assign tbl_rd_idx = bad_index ? '0 : s_stack_index[STK_IDX_W-1:0];

    // Decide the outcome at the input transfer. A push reuses the free list head when
    // there is one, and so must read that node's link; a pop reads the top node.
    always_comb begin
        acc_status   = STAT_OK;
        acc_node     = NIL_PTR;
        acc_use_free = 1'b0;
        acc_read     = 1'b0;
        if (bad_index) begin
            acc_status = STAT_BAD_INDEX;
        end else if (s_action == ACT_PUSH) begin
            if (free_head_reg != NIL_PTR) begin
                acc_node     = free_head_reg;
                acc_use_free = 1'b1;
                acc_read     = 1'b1;
            end else if (fresh_reg != NIL_PTR) begin
                acc_node = fresh_reg;
            end else begin
                acc_status = STAT_FULL;
            end
        end else begin
            if (tbl_rd_top == NIL_PTR) begin
                acc_status = STAT_EMPTY;
            end else begin
                acc_node = tbl_rd_top;
                acc_read = 1'b1;
            end
        end
    end

    // Write-back completes once the output register is free or being emptied.
    assign done = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign ok   = (status_reg == STAT_OK);

    // A push links the new node above the old top; a pop keeps the value and links the
    // node onto the free list.
    assign wr_data    = (act_reg == ACT_PUSH) ? node_t'{link: old_top_reg, value: val_reg}
                                              : node_t'{link: free_head_reg,
                                                        value: rd_data.value};
    assign tbl_wr_top = (act_reg == ACT_PUSH) ? node_reg : rd_data.link;

    msp_top_table u_top_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (tbl_rd_idx),
        .rd_top  (tbl_rd_top),
        .wr_en   (done && ok),
        .wr_idx  (idx_reg),
        .wr_top  (tbl_wr_top)
    );

    msp_node_ram u_node_ram (
        .aclk    (aclk),
        .rd_en   (in_xfer && acc_read),
        .rd_addr (acc_node[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (done && ok),
        .wr_addr (node_reg[ADDR_W-1:0]),
        .wr_data (wr_data)
    );

    always_comb begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (ok) begin
                        if (act_reg == ACT_POP) begin
                            free_head_next = node_reg;
                        end else if (use_free_reg) begin
                            free_head_next = rd_data.link;
                        end else begin
                            fresh_next = fresh_reg + ptr_t'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= NIL_PTR;
            fresh_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Operation payload, captured at the input transfer.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            act_reg      <= s_action;
            idx_reg      <= tbl_rd_idx;
            status_reg   <= acc_status;
            node_reg     <= acc_node;
            use_free_reg <= acc_use_free;
            old_top_reg  <= tbl_rd_top;
            val_reg      <= to_data(s_push_value);
        end
    end

    // Result payload; the popped value is zero for every push and every error.
    always_ff @(posedge aclk) begin
        if (done) begin
            m_status_reg <= status_reg;
            m_popped_reg <= (ok && act_reg == ACT_POP) ? from_data(rd_data.value) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_value = $signed(m_popped_reg);

    // The count of nodes handed out never passes the pool size.
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= NIL_PTR)
        else $error("fresh node count beyond pool size");

    // A node can only be on the free list after at least one node has been handed out.
    a_free_needs_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg != NIL_PTR) |-> (fresh_reg != '0))
        else $error("free list holds a node that was never handed out");

    // A failed operation never returns a value.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> (m_popped_value == '0))
        else $error("non-zero popped value with error status");

    // A result only appears after a write-back cycle.
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result presented without a write-back");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import msp_pkg::*;

    // Each transfer on the result channel carries a status and a popped value.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  popped;
    } stack_result_t;

    // One row of the directed sequence. Where has_fixed is set, the result is
    // written out by hand; otherwise the row is checked against the predictor.
    typedef struct packed {
        logic                act;
        logic [IDX_W-1:0]    idx;
        logic [FIELD_W-1:0]  val;
        logic                has_fixed;
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  popped;
    } directed_op_t;

    // Random phases: fill the pool, drain it, mix both, or hammer two stacks.
    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_FOCUS
    } phase_kind_t;

    localparam int NUM_DIRECTED = 23;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;

    // The directed sequence starts from reset: empty pops, bad indexes on both
    // operations (including indexes with the upper bits set), the extreme
    // values pushed and popped back in reverse order, and node reuse from the
    // free list once pops have returned nodes to it.
    localparam directed_op_t DIRECTED_OPS [NUM_DIRECTED] = '{
        '{ACT_POP,  6'd0,  32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_POP,  6'd9,  32'hFFFF_FFFF, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_PUSH, 6'd10, 32'h0000_0001, 1'b1, STAT_BAD_INDEX, 32'h0000_0000},
        '{ACT_POP,  6'd63, 32'h0000_0000, 1'b1, STAT_BAD_INDEX, 32'h0000_0000},
        '{ACT_PUSH, 6'd63, 32'hFFFF_FFFF, 1'b1, STAT_BAD_INDEX, 32'h0000_0000},
        '{ACT_PUSH, 6'd0,  32'h7FFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH, 6'd0,  32'h8000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd0,  32'h0000_0000, 1'b1, STAT_OK,        32'h8000_0000},
        '{ACT_POP,  6'd0,  32'h0000_0000, 1'b1, STAT_OK,        32'h7FFF_FFFF},
        '{ACT_POP,  6'd0,  32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_PUSH, 6'd9,  32'hFFFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH, 6'd9,  32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH, 6'd3,  32'hA5A5_A5A5, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd9,  32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd9,  32'h0000_0000, 1'b1, STAT_OK,        32'hFFFF_FFFF},
        '{ACT_PUSH, 6'd5,  32'h1234_5678, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd3,  32'h0000_0000, 1'b1, STAT_OK,        32'hA5A5_A5A5},
        '{ACT_PUSH, 6'd3,  32'h5A5A_5A5A, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd5,  32'hDEAD_BEEF, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd3,  32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_POP,  6'd5,  32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_POP,  6'd32, 32'h0000_0000, 1'b1, STAT_BAD_INDEX, 32'h0000_0000},
        '{ACT_PUSH, 6'd16, 32'h5555_5555, 1'b1, STAT_BAD_INDEX, 32'h0000_0000}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_action;
    logic [IDX_W-1:0]          s_stack_index;
    logic signed [FIELD_W-1:0] s_push_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [STATUS_W-1:0]       m_status;
    logic signed [FIELD_W-1:0] m_popped_value;

    // Predictor state: a private copy of the stacks, the node pool and the
    // free list, kept in step with every accepted input transfer.
    ptr_t  stack_head [NUM_STACKS];
    data_t pool_value [POOL_DEPTH];
    ptr_t  pool_link  [POOL_DEPTH];
    ptr_t  free_list_head;
    ptr_t  nodes_handed_out;

    // Results still owed by the block, oldest first.
    stack_result_t pending_results [$];

    int mismatch_count;
    int results_seen;

    multi_stack_shared_pool DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_stack_index  (s_stack_index),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped_value (m_popped_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Returns the predictor to its reset state: every stack empty, the free
    // list empty and no node yet taken from the pool.
    function automatic void clear_stacks();
        for (int i = 0; i < NUM_STACKS; i++) begin
            stack_head[i] = NIL_PTR;
        end
        free_list_head   = NIL_PTR;
        nodes_handed_out = '0;
    endfunction

    // Applies one push or pop to the predictor and returns the result that
    // the block should give for it. Any error leaves the state untouched.
    function automatic stack_result_t apply_stack_op(input logic act,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [FIELD_W-1:0] val);
        stack_result_t        res;
        ptr_t                 node;
        logic [ADDR_W-1:0]    slot;
        logic [STK_IDX_W-1:0] sidx;
        res.status = STAT_OK;
        res.popped = '0;
        node       = NIL_PTR;
        slot       = '0;
        sidx       = idx[STK_IDX_W-1:0];
        if (idx >= IDX_W'(NUM_STACKS)) begin
            res.status = STAT_BAD_INDEX;
        end else if (act == ACT_PUSH) begin
            // Recycled nodes are preferred; the untouched part of the pool
            // is only used once the free list has run dry.
            if (free_list_head < NIL_PTR) begin
                node           = free_list_head;
                free_list_head = pool_link[node[ADDR_W-1:0]];
            end else if (nodes_handed_out < NIL_PTR) begin
                node             = nodes_handed_out;
                nodes_handed_out = nodes_handed_out + ptr_t'(1);
            end else begin
                res.status = STAT_FULL;
            end
            if (node < NIL_PTR) begin
                slot             = node[ADDR_W-1:0];
                pool_value[slot] = data_t'(val);
                pool_link[slot]  = stack_head[sidx];
                stack_head[sidx] = node;
            end
        end else begin
            node = stack_head[sidx];
            if (node >= NIL_PTR) begin
                res.status = STAT_EMPTY;
            end else begin
                // The popped node goes to the head of the free list.
                slot             = node[ADDR_W-1:0];
                res.popped       = FIELD_W'(pool_value[slot]);
                stack_head[sidx] = pool_link[slot];
                pool_link[slot]  = free_list_head;
                free_list_head   = node;
            end
        end
        return res;
    endfunction

    // Drives one item after the given idle gap and holds it until the block
    // takes it. The expected result is queued at the edge of the transfer.
    // The valid line is only lowered when a gap really follows, so it never
    // falls and rises within the same time step.
    task automatic send_stack_op(input logic act, input logic [IDX_W-1:0] idx,
                                 input logic [FIELD_W-1:0] val, input int gap,
                                 input logic has_fixed, input stack_result_t fixed);
        stack_result_t predicted;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_stack_index <= idx;
        s_push_value  <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_stack_op(act, idx, val);
        // Hand-written rows still advance the predictor so that the rows
        // after them are predicted from the right state.
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    // Holds the sender back until every result owed has been taken. At least
    // one edge passes first, so valid is never lowered and raised in one step.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Picks a stack index; about one item in ten addresses a stack that does
    // not exist, so the upper index bits are exercised as well.
    function automatic logic [IDX_W-1:0] pick_index(input phase_kind_t kind,
                                                    input logic [IDX_W-1:0] hot_a,
                                                    input logic [IDX_W-1:0] hot_b);
        if ($urandom_range(0, 9) == 0) begin
            return IDX_W'($urandom_range(NUM_STACKS, (1 << IDX_W) - 1));
        end
        if (kind == PH_FOCUS) begin
            return $urandom_range(0, 1) ? hot_a : hot_b;
        end
        return IDX_W'($urandom_range(0, NUM_STACKS - 1));
    endfunction

    // Mostly random words, with the signed extremes and all-zero/all-one
    // patterns mixed in now and then.
    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: begin
                return {1'b0, {(FIELD_W - 1){1'b1}}};
            end
            1: begin
                return {1'b1, {(FIELD_W - 1){1'b0}}};
            end
            2: begin
                return '1;
            end
            3: begin
                return '0;
            end
            default: begin
                return FIELD_W'($urandom());
            end
        endcase
    endfunction

    // Result side: before every result the receiver stalls for a random
    // number of cycles, except in calm stretches where it is always ready.
    // Each transfer is compared field by field with the oldest expectation.
    initial begin
        stack_result_t want;
        int            stall;
        bit            calm;
        m_ready        <= 1'b0;
        results_seen   = 0;
        mismatch_count = 0;
        calm           = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result with nothing outstanding: status %0d value %h",
                             m_status, m_popped_value);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_popped_value !== want.popped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result %0d: status exp %0d got %0d, value exp %h got %h",
                                 results_seen, want.status, m_status,
                                 want.popped, m_popped_value);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel sees a transfer for too long.
    // The bound is far above the worst legal gap (sender pause, receiver
    // stall and the latency of the block added together).
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("multi_stack_shared_pool: mismatch");
        $finish;
    end

    // Stimulus: reset, the directed rows, then random phases.
    initial begin
        stack_result_t fixed;
        phase_kind_t   kind;
        logic          act;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] hot_a;
        logic [IDX_W-1:0] hot_b;
        int            sent;
        int            phase_len;
        int            phase_no;
        int            gap;
        int            push_weight;
        bit            calm;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_action      <= ACT_PUSH;
        s_stack_index <= '0;
        s_push_value  <= '0;
        clear_stacks();

        // Reset is held low and then released at a rising edge.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            fixed.status = DIRECTED_OPS[i].status;
            fixed.popped = DIRECTED_OPS[i].popped;
            send_stack_op(DIRECTED_OPS[i].act, DIRECTED_OPS[i].idx, DIRECTED_OPS[i].val,
                          $urandom_range(0, 6), DIRECTED_OPS[i].has_fixed, fixed);
        end

        // The sender waits here until every directed result has arrived.
        drain_results();

        fixed    = '0;
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            // The first phase only pushes, well past the size of the pool, so
            // that the pool is certain to run out; a bad index is then sent on
            // a full pool to show that the index check takes precedence.
            if (phase_no == 0) begin
                kind      = PH_FILL;
                phase_len = POOL_DEPTH + 8;
            end else begin
                kind      = phase_kind_t'($urandom_range(0, 3));
                phase_len = $urandom_range(30, 90);
            end
            case (kind)
                PH_FILL: begin
                    push_weight = (phase_no == 0) ? 100 : 85;
                end
                PH_DRAIN: begin
                    push_weight = 15;
                end
                default: begin
                    push_weight = 50;
                end
            endcase
            hot_a = IDX_W'($urandom_range(0, NUM_STACKS - 1));
            hot_b = IDX_W'($urandom_range(0, NUM_STACKS - 1));
            calm  = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < phase_len; n++) begin
                act = ($urandom_range(1, 100) <= push_weight) ? ACT_PUSH : ACT_POP;
                if (phase_no == 0) begin
                    idx = IDX_W'($urandom_range(0, NUM_STACKS - 1));
                end else begin
                    idx = pick_index(kind, hot_a, hot_b);
                end
                gap = calm ? 0 : $urandom_range(0, 6);
                send_stack_op(act, idx, pick_value(), gap, 1'b0, fixed);
                sent++;
            end

            if (phase_no == 0) begin
                send_stack_op(ACT_PUSH, IDX_W'($urandom_range(NUM_STACKS, 63)),
                              pick_value(), 0, 1'b0, fixed);
                send_stack_op(ACT_PUSH, IDX_W'($urandom_range(0, NUM_STACKS - 1)),
                              pick_value(), 0, 1'b0, fixed);
                sent += 2;
            end

            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
            phase_no++;
        end

        // All stimulus is in; wait for the last results and a short tail in
        // which any stray result would still be caught.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("multi_stack_shared_pool: match");
        end else begin
            $display("multi_stack_shared_pool: mismatch");
        end
        $finish;
    end

endmodule
